@@ hdl/clc_pkg.sv @@
// Shared types, codes and constants for the code lock controller.
package clc_pkg;

  // Number of digits in a code.
  localparam int unsigned CodeLength = 8;
  localparam int unsigned IdxW       = (CodeLength > 1) ? $clog2(CodeLength) : 1;
  localparam int unsigned CntW       = $clog2(CodeLength + 1);

  // Timing registers.
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] PressGapReset  = 16'd300;
  localparam logic [CfgW-1:0] TimeoutReset   = 16'd15000;
  localparam logic [CfgW-1:0] HoldReset      = 16'd5000;
  localparam logic [CfgW-1:0] LongPressReset = 16'd3000;
  localparam logic [CfgW-1:0] CountMax       = 16'hFFFF;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegPressGapMin  = 2'd0,
    RegEntryTimeout = 2'd1,
    RegUnlockHold   = 2'd2,
    RegLongPress    = 2'd3
  } cfg_reg_e;

  // Reset code, digit i sits in bit i and repeats every eight digits.
  localparam logic [7:0] CodeResetPattern = 8'b0110_1111;

  // Window entry that never equals a code digit.
  localparam logic [1:0] WindowMarker = 2'd2;

  // Request opcodes.
  typedef enum logic [1:0] {
    OpTick    = 2'd0,
    OpZeroKey = 2'd1,
    OpOneKey  = 2'd2,
    OpUnused  = 2'd3
  } op_e;

  // Mode codes as seen on the result.
  localparam logic [1:0] ModeCodeLocked   = 2'd0;
  localparam logic [1:0] ModeCodeUnlocked = 2'd1;
  localparam logic [1:0] ModeCodeEdit     = 2'd2;

  // Internal mode register, one-hot.
  typedef enum logic [2:0] {
    ModeLocked   = 3'b001,
    ModeUnlocked = 3'b010,
    ModeEdit     = 3'b100
  } mode_e;

  // Event codes.
  typedef enum logic [2:0] {
    EvNone        = 3'd0,
    EvDigitTaken  = 3'd1,
    EvOpened      = 3'd2,
    EvCodeStored  = 3'd3,
    EvTimeout     = 3'd4,
    EvRelocked    = 3'd5,
    EvEditEntered = 3'd6
  } event_e;

  typedef struct packed {
    logic [1:0] op;
    logic       edit_button;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] entry_count;
    logic [2:0] event_res;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] press_gap_min;
    logic [CfgW-1:0] entry_timeout;
    logic [CfgW-1:0] unlock_hold;
    logic [CfgW-1:0] long_press_ticks;
  } cfg_t;

  // Reset value of code digit i.
  function automatic logic code_reset_bit(int unsigned i);
    return CodeResetPattern[3'(i)];
  endfunction

endpackage

@@ hdl/clc_cfg_regs.sv @@
// Timing configuration registers of the code lock controller.
module clc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [clc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [clc_pkg::CfgW-1:0]    cfg_wdata_i,
  output clc_pkg::cfg_t               cfg_o
);
  import clc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegPressGapMin:  cfg_d.press_gap_min    = cfg_wdata_i;
        RegEntryTimeout: cfg_d.entry_timeout    = cfg_wdata_i;
        RegUnlockHold:   cfg_d.unlock_hold      = cfg_wdata_i;
        RegLongPress:    cfg_d.long_press_ticks = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_gap_min    <= PressGapReset;
      cfg_q.entry_timeout    <= TimeoutReset;
      cfg_q.unlock_hold      <= HoldReset;
      cfg_q.long_press_ticks <= LongPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/clc_core.sv @@
// Lock state and the single-pass next-state and result logic.
module clc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  clc_pkg::in_item_t  item_i,
  input  clc_pkg::cfg_t      cfg_i,
  output clc_pkg::out_item_t res_o
);
  import clc_pkg::*;

  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        win_q [CodeLength];
  logic [1:0]        win_d [CodeLength];
  logic              code_q [CodeLength];
  logic              code_d [CodeLength];
  logic [CfgW-1:0]   since_q, since_d;
  logic              armed_q, armed_d;
  logic [CfgW-1:0]   open_q, open_d;
  logic [CfgW-1:0]   hold_q, hold_d;
  event_e            ev;

  function automatic logic [CfgW-1:0] sat_inc(logic [CfgW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Next state and event for the request in hand.
  always_comb begin
    logic [CfgW-1:0] since_inc;
    logic [CfgW-1:0] hold_inc;
    logic [CfgW-1:0] open_inc;
    logic            digit;
    logic            match;
    logic [IdxW-1:0] idx;
    logic [CntW-1:0] cnt_inc;

    mode_d  = mode_q;
    cnt_d   = cnt_q;
    win_d   = win_q;
    code_d  = code_q;
    since_d = since_q;
    armed_d = armed_q;
    open_d  = open_q;
    hold_d  = hold_q;
    ev      = EvNone;

    since_inc = sat_inc(since_q);
    hold_inc  = item_i.edit_button ? sat_inc(hold_q) : '0;
    open_inc  = sat_inc(open_q);
    digit     = (item_i.op == OpOneKey);
    match     = 1'b0;
    idx       = '0;
    cnt_inc   = '0;

    unique case (op_e'(item_i.op))
      OpTick: begin
        if (item_i.edit_button && (hold_inc >= cfg_i.long_press_ticks)) begin
          // Long hold of the edit button enters edit from any mode.
          hold_d  = '0;
          mode_d  = ModeEdit;
          cnt_d   = '0;
          armed_d = 1'b0;
          since_d = CountMax;
          ev      = EvEditEntered;
        end else begin
          since_d = since_inc;
          hold_d  = hold_inc;
          if (mode_q == ModeUnlocked) begin
            open_d = open_inc;
            if (open_inc >= cfg_i.unlock_hold) begin
              mode_d = ModeLocked;
              ev     = EvRelocked;
            end
          end else if ((mode_q == ModeLocked) && armed_q) begin
            if (since_inc >= cfg_i.entry_timeout) begin
              for (int i = 0; i < CodeLength; i++) begin
                win_d[i] = WindowMarker;
              end
              cnt_d   = '0;
              armed_d = 1'b0;
              ev      = EvTimeout;
            end
          end
        end
      end
      OpZeroKey, OpOneKey: begin
        since_d = '0;
        armed_d = 1'b1;
        if (since_q >= cfg_i.press_gap_min) begin
          if (mode_q == ModeLocked) begin
            // Fill the window, or shift it once it is full.
            if (cnt_q < CntW'(CodeLength)) begin
              win_d[cnt_q[IdxW-1:0]] = {1'b0, digit};
              cnt_d = cnt_q + 1'b1;
            end else begin
              for (int i = 1; i < CodeLength; i++) begin
                win_d[i-1] = win_q[i];
              end
              win_d[CodeLength-1] = {1'b0, digit};
              cnt_d = CntW'(CodeLength);
            end
            match = 1'b1;
            for (int i = 0; i < CodeLength; i++) begin
              if (win_d[i] != {1'b0, code_q[i]}) begin
                match = 1'b0;
              end
            end
            if (match) begin
              mode_d = ModeUnlocked;
              cnt_d  = '0;
              for (int i = 0; i < CodeLength; i++) begin
                win_d[i] = WindowMarker;
              end
              open_d = '0;
              ev     = EvOpened;
            end else begin
              ev = EvDigitTaken;
            end
          end else if (mode_q == ModeEdit) begin
            // Write the next digit of the new code.
            idx = (cnt_q >= CntW'(CodeLength)) ? '0 : cnt_q[IdxW-1:0];
            code_d[idx] = digit;
            cnt_inc = CntW'(idx) + 1'b1;
            if (cnt_inc >= CntW'(CodeLength)) begin
              cnt_d  = '0;
              mode_d = ModeLocked;
              ev     = EvCodeStored;
            end else begin
              cnt_d = cnt_inc;
              ev    = EvDigitTaken;
            end
          end
        end
      end
      default: begin
        ev = EvNone;
      end
    endcase
  end

  // State registers, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeLocked;
      cnt_q   <= '0;
      since_q <= CountMax;
      armed_q <= 1'b0;
      open_q  <= '0;
      hold_q  <= '0;
      for (int i = 0; i < CodeLength; i++) begin
        win_q[i]  <= '0;
        code_q[i] <= code_reset_bit(i);
      end
    end else if (step_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      since_q <= since_d;
      armed_q <= armed_d;
      open_q  <= open_d;
      hold_q  <= hold_d;
      win_q   <= win_d;
      code_q  <= code_d;
    end
  end

  // Result fields reflect the state after the request.
  always_comb begin
    unique case (mode_d)
      ModeLocked:   res_o.mode = ModeCodeLocked;
      ModeUnlocked: res_o.mode = ModeCodeUnlocked;
      ModeEdit:     res_o.mode = ModeCodeEdit;
      default:      res_o.mode = ModeCodeLocked;
    endcase
    res_o.entry_count = 4'(cnt_d);
    res_o.event_res   = ev;
  end

endmodule

@@ hdl/code_lock_controller_top.sv @@
// Top level of the code lock controller: request and result stages.
//
// Requests arrive on in_valid_i / in_ready_o with in_data_i: a tick that
// carries the edit button level, or a zero-key or one-key press. Every
// request gives exactly one result on out_valid_o / out_ready_i with
// out_data_o: the mode after the request, the digit count and an event.
// A request is held in an input register, worked through the lock logic
// and its result loaded into the output register once that register is
// free. One request is taken every cycle while the receiver keeps up;
// the only loop is the update of the lock state by each request.
// When the receiver stalls, the result waits in the output register and
// one more request is held in the input register; in_ready_o then falls.
// The timing registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must write them only while no request is in
// flight, which the block itself does not enforce. Reset clears both
// stages, locks the lock, loads the default code and default timings.
module code_lock_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  clc_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output clc_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [clc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [clc_pkg::CfgW-1:0]    cfg_wdata_i
);
  import clc_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  logic      step;
  logic      out_free;

  logic      req_valid_q, req_valid_d;
  in_item_t  req_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  clc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  clc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Handshake between the two stages.
  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = req_valid_q && out_free;
  assign in_ready_o  = !req_valid_q || step;
  assign req_valid_d = in_ready_o ? in_valid_i : req_valid_q;
  assign out_valid_d = out_free ? step : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
